// ===== hdl/cmr_pkg.sv =====
// Shared types and constants for the combining mark reorder block.
package cmr_pkg;

    localparam int CharW  = 8;
    localparam int CountW = 16;
    localparam int LevelW = 3;
    localparam int Slots  = 3;

    localparam logic [CountW-1:0] LimitReset = 16'hFFFF;

    localparam logic signed [LevelW-1:0] LVL_BELOW = -3'sd1;
    localparam logic signed [LevelW-1:0] LVL_BASE  = 3'sd0;
    localparam logic signed [LevelW-1:0] LVL_ABOVE = 3'sd1;
    localparam logic signed [LevelW-1:0] LVL_TONE  = 3'sd2;
    localparam logic signed [LevelW-1:0] LVL_MARK3 = 3'sd3;

    // One queued job: the compacted characters to emit, how many, whether a
    // terminator follows, and the written count before the first of them.
    typedef struct packed {
        logic [Slots-1:0][CharW-1:0] chars;
        logic [1:0]                  n_chars;
        logic                        term;
        logic [CountW-1:0]           cnt0;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_qwr;

    typedef struct packed {
        logic not_empty;
        t_job job;
    } t_qrd;

endpackage

// ===== hdl/cmr_front.sv =====
// Front end: accepts items, keeps the cluster and room, builds flush jobs.
module cmr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [cmr_pkg::CharW-1:0]     i_char_code,
    input  logic signed [cmr_pkg::LevelW-1:0] i_char_level,
    input  logic                          i_end_of_string,
    input  logic                          i_cfg_we,
    input  logic [cmr_pkg::CountW-1:0]    i_cfg_data,
    output cmr_pkg::t_qwr                 o_qwr
);
    import cmr_pkg::*;

    logic [CountW-1:0] r_limit, n_limit;
    logic [CountW-1:0] r_room, n_room;
    logic [CharW-1:0]  r_base, n_base;
    logic [CharW-1:0]  r_below, n_below;
    logic [CharW-1:0]  r_above, n_above;
    logic              r_above3, n_above3;
    logic [CharW-1:0]  r_top, n_top;

    logic              has_mid, has_top, can_flush, room_ok;
    logic [CharW-1:0]  mid_char;
    logic [1:0]        n_cand, n_emit;
    logic [CountW-1:0] room_m1;
    t_job              job;

    assign has_mid   = (r_below != '0) || (r_above != '0);
    assign mid_char  = (r_below != '0) ? r_below : r_above;
    assign has_top   = (r_top != '0);
    assign room_ok   = (r_room > CountW'(1));
    assign can_flush = room_ok && (r_base != '0);
    assign n_cand    = 2'd1 + {1'b0, has_mid} + {1'b0, has_top};
    assign room_m1   = r_room - CountW'(1);

    always_comb begin
        if (!can_flush) begin
            n_emit = 2'd0;
        end else if (room_m1 < {{(CountW-2){1'b0}}, n_cand}) begin
            n_emit = room_m1[1:0];
        end else begin
            n_emit = n_cand;
        end
    end

    always_comb begin
        job.chars[0] = r_base;
        job.chars[1] = has_mid ? mid_char : r_top;
        job.chars[2] = r_top;
        job.n_chars  = n_emit;
        job.term     = i_end_of_string;
        job.cnt0     = r_limit - r_room;
    end

    always_comb begin
        n_limit  = r_limit;
        n_room   = r_room;
        n_base   = r_base;
        n_below  = r_below;
        n_above  = r_above;
        n_above3 = r_above3;
        n_top    = r_top;
        o_qwr.push = 1'b0;
        o_qwr.job  = job;
        if (i_cfg_we) begin
            n_limit  = i_cfg_data;
            n_room   = i_cfg_data;
            n_base   = '0;
            n_below  = '0;
            n_above  = '0;
            n_above3 = 1'b0;
            n_top    = '0;
        end else if (i_accept && i_end_of_string) begin
            o_qwr.push = 1'b1;
            n_room     = r_limit;
            n_base     = '0;
            n_below    = '0;
            n_above    = '0;
            n_above3   = 1'b0;
            n_top      = '0;
        end else if (i_accept && room_ok) begin
            case (i_char_level)
                LVL_BASE: begin
                    o_qwr.push = (n_emit != 2'd0);
                    n_room     = r_room - CountW'(n_emit);
                    n_base     = i_char_code;
                    n_below    = '0;
                    n_above    = '0;
                    n_above3   = 1'b0;
                    n_top      = '0;
                end
                LVL_BELOW: n_below = i_char_code;
                LVL_ABOVE: begin
                    if ((r_above != '0) && r_above3) begin
                        n_top = r_above;
                    end
                    n_above  = i_char_code;
                    n_above3 = 1'b0;
                end
                LVL_TONE: n_top = i_char_code;
                LVL_MARK3: begin
                    if (r_above == '0) begin
                        n_above  = i_char_code;
                        n_above3 = 1'b1;
                    end else begin
                        n_top = i_char_code;
                    end
                end
                default: ;  // undefined levels are ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LimitReset;
            r_room   <= LimitReset;
            r_base   <= '0;
            r_below  <= '0;
            r_above  <= '0;
            r_above3 <= 1'b0;
            r_top    <= '0;
        end else begin
            r_limit  <= n_limit;
            r_room   <= n_room;
            r_base   <= n_base;
            r_below  <= n_below;
            r_above  <= n_above;
            r_above3 <= n_above3;
            r_top    <= n_top;
        end
    end

endmodule

// ===== hdl/cmr_queue.sv =====
// Small job queue between the front end and the output sequencer.
module cmr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cmr_pkg::t_qwr i_qwr,
    input  logic          i_pop,
    output cmr_pkg::t_qrd o_qrd,
    output logic          o_full
);
    import cmr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full          = (r_count == CW'(DEPTH));
    assign o_qrd.not_empty = (r_count != '0);
    assign o_qrd.job       = r_mem[r_rd_ptr];

    assign do_push = i_qwr.push && !o_full;
    assign do_pop  = i_pop && o_qrd.not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        n_count = r_count + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_qwr.job;
        end
    end

endmodule

// ===== hdl/cmr_back.sv =====
// Back end: walks the head job one result per cycle, while the output is not stalled, into the output register.
module cmr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cmr_pkg::t_qrd              i_qrd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cmr_pkg::CharW-1:0]  o_out_char,
    output logic                       o_is_terminator,
    output logic [cmr_pkg::CountW-1:0] o_written_count,
    output logic                       o_last_of_run
);
    import cmr_pkg::*;

    logic [1:0]        r_pos, n_pos;
    logic              r_valid, n_valid;
    logic [CharW-1:0]  r_char;
    logic              r_term;
    logic [CountW-1:0] r_count;
    logic              r_last;

    logic              load, is_char, last;
    logic [2:0]        total;
    logic [CountW-1:0] count;
    logic [CharW-1:0]  ch;

    assign load    = i_qrd.not_empty && (!r_valid || !i_stall);
    assign is_char = (r_pos < i_qrd.job.n_chars);
    assign total   = {1'b0, i_qrd.job.n_chars} + {2'b00, i_qrd.job.term};
    assign last    = ({1'b0, r_pos} == total - 3'd1);
    assign ch      = is_char ? i_qrd.job.chars[r_pos] : '0;
    // chars count themselves; the terminator carries the total so far
    assign count   = i_qrd.job.cnt0 + CountW'(r_pos) + CountW'(is_char);
    assign o_pop   = load && last;

    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid && i_stall;
        if (load) begin
            n_valid = 1'b1;
            n_pos   = last ? 2'd0 : r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char  <= ch;
            r_term  <= !is_char;
            r_count <= count;
            r_last  <= last;
        end
    end

    assign o_valid         = r_valid;
    assign o_out_char      = r_char;
    assign o_is_terminator = r_term;
    assign o_written_count = r_count;
    assign o_last_of_run   = r_last;

endmodule

// ===== hdl/combining_mark_reorder_core.sv =====
// Top level of the combining mark reorder block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | i_valid / o_stall    | i_char_code, i_char_level, i_end_of_string
//  output   | o_valid / i_stall    | o_out_char, o_is_terminator, o_written_count,
//           |                      | o_last_of_run
//  config   | i_cfg_we             | i_cfg_data (out_limit)
//
// The front end takes one item per cycle while the job queue has a free slot;
// each item that yields results queues one job.
// The back end emits one result per cycle while i_stall is low, so a job with
// 1 to 4 results holds it until all are emitted; the queue absorbs short bursts.
// Results pass through the job queue and then the output register before they are valid.
// Reset is synchronous and needs no clearing pass; out_limit returns to 65535.
// o_stall follows queue fullness only; the output register holds under i_stall.
module combining_mark_reorder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cmr_pkg::CharW-1:0]         i_char_code,
    input  logic signed [cmr_pkg::LevelW-1:0] i_char_level,
    input  logic                              i_end_of_string,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cmr_pkg::CharW-1:0]         o_out_char,
    output logic                              o_is_terminator,
    output logic [cmr_pkg::CountW-1:0]        o_written_count,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_we,
    input  logic [cmr_pkg::CountW-1:0]        i_cfg_data
);
    import cmr_pkg::*;

    t_qwr qwr;
    t_qrd qrd;
    logic q_full, pop, accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    cmr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_code     (i_char_code),
        .i_char_level    (i_char_level),
        .i_end_of_string (i_end_of_string),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_qwr           (qwr)
    );

    cmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (pop),
        .o_qrd   (qrd),
        .o_full  (q_full)
    );

    cmr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qrd           (qrd),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_char      (o_out_char),
        .o_is_terminator (o_is_terminator),
        .o_written_count (o_written_count),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

// ===== hdl/cmr_checker.sv =====
// Port-level checks for the combining mark reorder block, bound to the top.
module cmr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [cmr_pkg::CharW-1:0]         i_char_code,
    input logic signed [cmr_pkg::LevelW-1:0] i_char_level,
    input logic                              i_end_of_string,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [cmr_pkg::CharW-1:0]         o_out_char,
    input logic                              o_is_terminator,
    input logic [cmr_pkg::CountW-1:0]        o_written_count,
    input logic                              o_last_of_run
);
    import cmr_pkg::*;

    // a stalled input item stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_char_code)
            && $stable(i_char_level) && $stable(i_end_of_string)))
        else $error("stalled input item changed");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_char)
            && $stable(o_written_count) && $stable(o_is_terminator)))
        else $error("stalled result changed");

    // the terminator always closes its item's run and carries a zero byte
    a_term_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_terminator) |-> (o_last_of_run && (o_out_char == '0)))
        else $error("terminator not last or nonzero");

    // a written character counts itself
    a_char_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_terminator) |-> (o_written_count != '0))
        else $error("character with zero count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind combining_mark_reorder_core cmr_checker u_cmr_checker (.*);
